### rtl/imu_shm_pkg.sv
// Package for the IMU sample health monitor: payload structs, register codes,
// reset values and sizing constants. Depends on nothing; every rtl file imports it.
package imu_shm_pkg;

    // Sizing
    localparam int SENSOR_COUNT = 2;
    localparam int AXES         = 6;
    localparam int SAMPLE_W     = 16;
    localparam int RUN_W        = 16;
    localparam int COUNT_W      = 32;
    localparam int THRESH_W     = 16;
    localparam int MASK_W       = 2;
    localparam int CFG_DATA_W   = 16;

    // Sample extremes
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_RAIL_HI = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_RAIL_LO = 16'sh8000;
    localparam logic [RUN_W-1:0]           RUN_MAX        = '1;

    // Register reset values
    localparam logic [THRESH_W-1:0] FROZEN_THRESHOLD_RESET = 16'd50;
    localparam logic [MASK_W-1:0]   REPEAT_MASK_RESET      = 2'd2;

    // Register indexes
    typedef enum logic [0:0] {
        REG_FROZEN_THRESHOLD = 1'b0,
        REG_REPEAT_MASK      = 1'b1
    } imu_shm_reg_t;

    typedef logic signed [SAMPLE_W-1:0] imu_shm_sample_t;

    // One sensor read
    typedef struct packed {
        logic            sensor;
        logic            read_ok;
        logic            fresh;
        imu_shm_sample_t accel_x;
        imu_shm_sample_t accel_y;
        imu_shm_sample_t accel_z;
        imu_shm_sample_t gyro_x;
        imu_shm_sample_t gyro_y;
        imu_shm_sample_t gyro_z;
    } imu_shm_in_t;

    // One status result
    typedef struct packed {
        logic               sensor_out;
        logic               read_fail;
        logic               repeated;
        logic               accel_saturated;
        logic               gyro_saturated;
        logic               frozen_fault;
        logic [COUNT_W-1:0] read_error_count;
        logic [COUNT_W-1:0] repeat_count;
    } imu_shm_out_t;

    // Counter control from the check logic
    typedef struct packed {
        logic advance;
        logic fail_read;
        logic stale_counted;
    } imu_shm_cnt_ctrl_t;

endpackage

### rtl/imu_shm_sensor_state.sv
// Per-sensor history: last sample of every axis and the run of identical samples.
// Produces the frozen fault for the current read. Depends on imu_shm_pkg.
module imu_shm_sensor_state
    import imu_shm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                update,
    input  logic                sensor,
    input  imu_shm_sample_t     sample [AXES],
    input  logic [THRESH_W-1:0] frozen_threshold,
    output logic                frozen_fault
);

    imu_shm_sample_t  last_sample_reg   [SENSOR_COUNT][AXES];
    logic [RUN_W-1:0] identical_run_reg [SENSOR_COUNT];
    logic [RUN_W-1:0] run_next;
    logic             identical;

    // Compare the read against the stored sample of its sensor
    always_comb
    begin
        identical = 1'b1;
        for (int a = 0; a < AXES; a++)
        begin
            if (sample[a] != last_sample_reg[sensor][a])
            begin
                identical = 1'b0;
            end
        end
    end

    // Extend the run, hold it at its ceiling, or drop it on a change
    always_comb
    begin
        if (!identical)
        begin
            run_next = '0;
        end
        else if (identical_run_reg[sensor] == RUN_MAX)
        begin
            run_next = identical_run_reg[sensor];
        end
        else
        begin
            run_next = identical_run_reg[sensor] + 1'b1;
        end
    end

    assign frozen_fault = (run_next >= frozen_threshold);

    // Store the sample and run of the sensor on a good read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SENSOR_COUNT; s++)
            begin
                identical_run_reg[s] <= '0;
                for (int a = 0; a < AXES; a++)
                begin
                    last_sample_reg[s][a] <= '0;
                end
            end
        end
        else if (update)
        begin
            identical_run_reg[sensor] <= run_next;
            for (int a = 0; a < AXES; a++)
            begin
                last_sample_reg[sensor][a] <= sample[a];
            end
        end
    end

endmodule

### rtl/imu_shm_counters.sv
// Wrapping counters of failed reads and of counted stale reads.
// Shows the values after the current read. Depends on imu_shm_pkg.
module imu_shm_counters
    import imu_shm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  imu_shm_cnt_ctrl_t  ctrl,
    output logic [COUNT_W-1:0] error_count,
    output logic [COUNT_W-1:0] repeat_count
);

    logic [COUNT_W-1:0] error_counter_reg;
    logic [COUNT_W-1:0] repeat_counter_reg;
    logic [COUNT_W-1:0] error_counter_next;
    logic [COUNT_W-1:0] repeat_counter_next;

    // Bump each counter on its event
    always_comb
    begin
        error_counter_next  = error_counter_reg + COUNT_W'(ctrl.fail_read);
        repeat_counter_next = repeat_counter_reg + COUNT_W'(ctrl.stale_counted);
    end

    assign error_count  = error_counter_next;
    assign repeat_count = repeat_counter_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_counter_reg  <= '0;
            repeat_counter_reg <= '0;
        end
        else if (ctrl.advance)
        begin
            error_counter_reg  <= error_counter_next;
            repeat_counter_reg <= repeat_counter_next;
        end
    end

endmodule

### rtl/imu_sample_health_monitor_core.sv
// Top level of the IMU sample health monitor: input register, checks, result register.
// Depends on imu_shm_pkg, imu_shm_sensor_state and imu_shm_counters.
//
// Usage:
//   item (valid/ready) carries one six-axis sensor read per transfer; status
//   (valid/ready) returns one health result per read, in order.
//   A read is captured in an input register, checked by short logic against
//   the stored history of its sensor, and the result is captured in an output
//   register, which drives status_valid.
//   Throughput is one read per cycle while status_ready is high; the input and output
//   registers form a two-entry pipeline, so a new read is taken while a result waits.
//   When the receiver stalls, the result holds in the output register; one
//   more read may wait in the input register, then item_ready drops.
//   Reset clears the history, the counters and both pipeline stages, and
//   loads frozen_threshold = 50 and repeat_count_mask = 2.
//   cfg_we writes cfg_data to register cfg_index in the same cycle
//   (0: frozen_threshold, 1: repeat_count_mask in bits 1:0); write only
//   while the block holds no read.
module imu_sample_health_monitor_core
    import imu_shm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  imu_shm_in_t           item,
    output logic                  status_valid,
    input  logic                  status_ready,
    output imu_shm_out_t          status,
    input  logic                  cfg_we,
    input  imu_shm_reg_t          cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [THRESH_W-1:0] frozen_threshold_reg;
    logic [MASK_W-1:0]   repeat_mask_reg;
    logic                item_valid_reg;
    imu_shm_in_t         item_reg;
    logic                status_valid_reg;
    imu_shm_out_t        status_reg;
    imu_shm_out_t        status_next;

    logic                advance;
    logic                good_read;
    logic                stale;
    logic                mask_hit;
    logic                frozen_fault;
    logic                accel_sat;
    logic                gyro_sat;
    imu_shm_sample_t     sample [AXES];
    imu_shm_cnt_ctrl_t   cnt_ctrl;
    logic [COUNT_W-1:0]  error_count;
    logic [COUNT_W-1:0]  repeat_count;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frozen_threshold_reg <= FROZEN_THRESHOLD_RESET;
            repeat_mask_reg      <= REPEAT_MASK_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FROZEN_THRESHOLD: frozen_threshold_reg <= cfg_data[THRESH_W-1:0];
                REG_REPEAT_MASK:      repeat_mask_reg      <= cfg_data[MASK_W-1:0];
            endcase
        end
    end

    // Pipeline control: advance when the result register is free or drains
    assign advance    = item_valid_reg && (!status_valid_reg || status_ready);
    assign item_ready = !item_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            item_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

    // Checks on the held read
    assign sample[0] = item_reg.accel_x;
    assign sample[1] = item_reg.accel_y;
    assign sample[2] = item_reg.accel_z;
    assign sample[3] = item_reg.gyro_x;
    assign sample[4] = item_reg.gyro_y;
    assign sample[5] = item_reg.gyro_z;

    assign good_read = item_reg.read_ok && (int'(item_reg.sensor) < SENSOR_COUNT);
    assign stale     = good_read && !item_reg.fresh;
    assign mask_hit  = repeat_mask_reg[item_reg.sensor];

    always_comb
    begin
        accel_sat = 1'b0;
        gyro_sat  = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            if (sample[a] == SAMPLE_RAIL_HI || sample[a] == SAMPLE_RAIL_LO)
            begin
                accel_sat = 1'b1;
            end
            if (sample[a+3] == SAMPLE_RAIL_HI || sample[a+3] == SAMPLE_RAIL_LO)
            begin
                gyro_sat = 1'b1;
            end
        end
    end

    imu_shm_sensor_state u_state (
        .clk              (clk),
        .rst_n            (rst_n),
        .update           (advance && good_read),
        .sensor           (item_reg.sensor),
        .sample           (sample),
        .frozen_threshold (frozen_threshold_reg),
        .frozen_fault     (frozen_fault)
    );

    assign cnt_ctrl.advance       = advance;
    assign cnt_ctrl.fail_read     = !good_read;
    assign cnt_ctrl.stale_counted = stale && mask_hit;

    imu_shm_counters u_counters (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (cnt_ctrl),
        .error_count  (error_count),
        .repeat_count (repeat_count)
    );

    // Assemble the result; a failed read clears the other flags
    always_comb
    begin
        status_next.sensor_out       = item_reg.sensor;
        status_next.read_fail        = !good_read;
        status_next.repeated         = stale;
        status_next.accel_saturated  = good_read && accel_sat;
        status_next.gyro_saturated   = good_read && gyro_sat;
        status_next.frozen_fault     = good_read && frozen_fault;
        status_next.read_error_count = error_count;
        status_next.repeat_count     = repeat_count;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            status_valid_reg <= 1'b1;
        end
        else if (status_ready)
        begin
            status_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg <= status_next;
        end
    end

    assign status_valid = status_valid_reg;
    assign status       = status_reg;

endmodule

### rtl/imu_shm_checker.sv
// Port-level checks for the IMU sample health monitor, bound to the top level.
// Depends on imu_shm_pkg and imu_sample_health_monitor_core.
module imu_shm_checker
    import imu_shm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_ready,
    input  logic                  status_valid,
    input  logic                  status_ready,
    input  imu_shm_out_t          status
);

    // An empty result register never blocks the input side
    a_ready_when_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        !status_valid |-> item_ready
    ) else $error("item_ready low with no result pending");

    // A failed read carries no other flag
    a_fail_clears_flags: assert property (
        @(posedge clk) disable iff (!rst_n)
        (status_valid && status.read_fail) |->
            !(status.repeated || status.accel_saturated ||
              status.gyro_saturated || status.frozen_fault)
    ) else $error("flags set on a failed read");

    // A stalled result holds
    a_stall_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (status_valid && !status_ready) |=> (status_valid && $stable(status))
    ) else $error("stalled result changed");

endmodule

bind imu_sample_health_monitor_core imu_shm_checker u_checker (.*);
